FILE: rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by rtl/modular_exponentiation.sv; depends on nothing else.
package modexp_pkg;

   localparam int BASE_WIDTH      = 64;
   localparam int EXP_FIELD_WIDTH = 32;
   localparam int MOD_FIELD_WIDTH = 32;
   localparam int RESULT_WIDTH    = 32;

   localparam logic [MOD_FIELD_WIDTH-1:0] MODULUS_RESET = 32'd1061743811;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_NEXT,
      ST_DONE
   } state_type;

   // What the shared serial multiplier is working on.
   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_SQUARE,
      OP_MULTIPLY
   } op_type;

endpackage

FILE: rtl/modular_exponentiation.sv
// One bit-serial modular multiplier, one bit per cycle, does the base reduction and every
// squaring and multiply. One transaction is in work at a time; the next can be taken in the
// cycle after its result is loaded, and a zero modulus goes straight to a zero result.
// Synchronous active-high reset returns the controller to idle, clears the result valid
// flag and sets the modulus to 1061743811.
module modular_exponentiation #(
   parameter int EXP_WIDTH = 32,
   parameter int MOD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [modexp_pkg::BASE_WIDTH-1:0]      req_base,
   input  logic [modexp_pkg::EXP_FIELD_WIDTH-1:0] req_exponent,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [modexp_pkg::RESULT_WIDTH-1:0]    rsp_result,
   input  logic                                   csr_write,
   input  logic [modexp_pkg::MOD_FIELD_WIDTH-1:0] csr_wdata
);

   localparam int SW     = MOD_WIDTH + 3;
   localparam int STEP_W = $clog2(modexp_pkg::BASE_WIDTH);
   localparam int EBIT_W = $clog2(EXP_WIDTH);
   localparam int PAD_W  = modexp_pkg::BASE_WIDTH - MOD_WIDTH;

   modexp_pkg::state_type state_ff, state_in;
   modexp_pkg::op_type    op_ff, op_in;

   logic [MOD_WIDTH-1:0]              csr_mod_ff, csr_mod_in;
   logic [MOD_WIDTH-1:0]              m_ff, m_in;
   logic [MOD_WIDTH-1:0]              a_ff, a_in;
   logic [MOD_WIDTH-1:0]              r_ff, r_in;
   logic [MOD_WIDTH-1:0]              bred_ff, bred_in;
   logic [MOD_WIDTH-1:0]              acc_ff, acc_in;
   logic [modexp_pkg::BASE_WIDTH-1:0] sh_ff, sh_in;
   logic [EXP_WIDTH-1:0]              exp_ff, exp_in;
   logic [EBIT_W-1:0]                 ebit_ff, ebit_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic signed [SW-1:0]              am1_ff, am1_in;
   logic signed [SW-1:0]              am2_ff, am2_in;
   logic signed [SW-1:0]              nm_ff, nm_in;
   logic [modexp_pkg::RESULT_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic signed [SW-1:0] r2, k0, k1, c0, c1, c2;
   logic [MOD_WIDTH-1:0] prod;
   logic [MOD_WIDTH-1:0] one_init;
   logic                 mul_bit;
   logic                 mul_last;
   logic                 exp_last;
   logic                 req_take;
   logic                 rsp_free;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign mul_bit  = sh_ff[modexp_pkg::BASE_WIDTH-1];
   assign mul_last = (op_ff == modexp_pkg::OP_REDUCE) ?
                     (step_ff == STEP_W'(modexp_pkg::BASE_WIDTH - 1)) :
                     (step_ff == STEP_W'(MOD_WIDTH - 1));
   assign exp_last = (ebit_ff == EBIT_W'(EXP_WIDTH - 1));
   assign one_init = (m_ff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

   // One step of interleaved modular multiplication: r = 2r + bit * a, brought back below
   // m. The sum stays below 3m, so the candidates minus m and minus 2m are formed in
   // parallel from offsets prepared in the load cycle, and the signs pick the winner.
   always_comb begin
      r2 = signed'(SW'({r_ff, 1'b0}));
      k0 = mul_bit ? signed'(SW'(a_ff)) : '0;
      k1 = mul_bit ? am1_ff : nm_ff;
      c0 = r2 + k0;
      c1 = r2 + k1;
      c2 = r2 + am2_ff;
      if (mul_bit && !c2[SW-1]) begin
         prod = c2[MOD_WIDTH-1:0];
      end else if (!c1[SW-1]) begin
         prod = c1[MOD_WIDTH-1:0];
      end else begin
         prod = c0[MOD_WIDTH-1:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (csr_mod_ff == '0) ? modexp_pkg::ST_DONE : modexp_pkg::ST_LOAD;
            end
         end
         modexp_pkg::ST_LOAD: begin
            state_in = modexp_pkg::ST_MUL;
         end
         modexp_pkg::ST_MUL: begin
            if (mul_last) begin
               state_in = modexp_pkg::ST_NEXT;
            end
         end
         modexp_pkg::ST_NEXT: begin
            state_in = modexp_pkg::ST_LOAD;
            if (op_ff != modexp_pkg::OP_REDUCE && exp_last) begin
               if (op_ff == modexp_pkg::OP_MULTIPLY || !exp_ff[EXP_WIDTH-1]) begin
                  state_in = modexp_pkg::ST_DONE;
               end
            end
         end
         modexp_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = modexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall  = (state_ff != modexp_pkg::ST_IDLE);
      rsp_valid  = rsp_valid_ff;
      rsp_result = rsp_result_ff;
   end

   // Datapath.
   always_comb begin
      csr_mod_in    = csr_write ? MOD_WIDTH'(csr_wdata) : csr_mod_ff;
      op_in         = op_ff;
      m_in          = m_ff;
      a_in          = a_ff;
      r_in          = r_ff;
      bred_in       = bred_ff;
      acc_in        = acc_ff;
      sh_in         = sh_ff;
      exp_in        = exp_ff;
      ebit_in       = ebit_ff;
      step_in       = step_ff;
      am1_in        = am1_ff;
      am2_in        = am2_ff;
      nm_in         = nm_ff;
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_take) begin
               // The base reduction is a serial multiply of one by the base bits.
               m_in    = csr_mod_ff;
               op_in   = modexp_pkg::OP_REDUCE;
               a_in    = MOD_WIDTH'(1);
               sh_in   = req_base;
               exp_in  = EXP_WIDTH'(req_exponent);
               ebit_in = '0;
               acc_in  = '0;
            end
         end
         modexp_pkg::ST_LOAD: begin
            am1_in  = signed'(SW'(a_ff)) - signed'(SW'(m_ff));
            am2_in  = signed'(SW'(a_ff)) - signed'(SW'({m_ff, 1'b0}));
            nm_in   = -signed'(SW'(m_ff));
            r_in    = '0;
            step_in = '0;
         end
         modexp_pkg::ST_MUL: begin
            r_in    = prod;
            sh_in   = {sh_ff[modexp_pkg::BASE_WIDTH-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
         end
         modexp_pkg::ST_NEXT: begin
            case (op_ff)
               modexp_pkg::OP_REDUCE: begin
                  bred_in = r_ff;
                  acc_in  = one_init;
                  op_in   = modexp_pkg::OP_SQUARE;
                  a_in    = one_init;
                  sh_in   = {one_init, {PAD_W{1'b0}}};
               end
               default: begin
                  acc_in = r_ff;
                  if (op_ff == modexp_pkg::OP_SQUARE && exp_ff[EXP_WIDTH-1]) begin
                     op_in = modexp_pkg::OP_MULTIPLY;
                     a_in  = bred_ff;
                     sh_in = {r_ff, {PAD_W{1'b0}}};
                  end else begin
                     // Move on to the next exponent bit with a fresh squaring.
                     ebit_in = ebit_ff + EBIT_W'(1);
                     exp_in  = {exp_ff[EXP_WIDTH-2:0], 1'b0};
                     op_in   = modexp_pkg::OP_SQUARE;
                     a_in    = r_ff;
                     sh_in   = {r_ff, {PAD_W{1'b0}}};
                  end
               end
            endcase
         end
         modexp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_result_in = modexp_pkg::RESULT_WIDTH'(acc_ff);
               rsp_valid_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         op_ff        <= modexp_pkg::OP_REDUCE;
         csr_mod_ff   <= MOD_WIDTH'(modexp_pkg::MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         ebit_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         csr_mod_ff   <= csr_mod_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         ebit_ff      <= ebit_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff          <= m_in;
      a_ff          <= a_in;
      r_ff          <= r_in;
      bred_ff       <= bred_in;
      acc_ff        <= acc_in;
      sh_ff         <= sh_in;
      exp_ff        <= exp_in;
      am1_ff        <= am1_in;
      am2_ff        <= am2_in;
      nm_ff         <= nm_in;
      rsp_result_ff <= rsp_result_in;
   end

   // The partial remainder is always fully reduced while the multiplier runs.
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == modexp_pkg::ST_MUL |-> r_ff < m_ff)
      else $error("partial remainder not below the modulus");

   // An accepted transaction always takes the controller out of idle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != modexp_pkg::ST_IDLE)
      else $error("controller stayed idle after accepting a transaction");

   // A result only appears when a computation has just finished.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == modexp_pkg::ST_DONE)
      else $error("result raised without a finished computation");

endmodule
